FILE: rtl/core/dam_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dam_pkg
// Shared types and constants of the ducking automation mixer: item codes,
// status codes, register indexes, stream layout and the command and status
// groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package dam_pkg;

    // Number of mixed sources; the datapath is built for exactly two.
    localparam int SOURCES = 2;

    // Q16 unity gain and the offset-binary midpoint.
    localparam logic [16:0] UNITY_Q16   = 17'd65536;
    localparam logic [31:0] UNITY_WIDE  = 32'd65536;
    localparam logic [16:0] MIDPOINT    = 17'd32768;
    localparam int          FRAC_BITS   = 16;

    // Stream widths of the input and output tdata and tuser.
    localparam int S_TDATA_W  = 168;
    localparam int S_TUSER_W  = 3;
    localparam int M_TDATA_W  = 32;
    localparam int M_TUSER_W  = 2;

    // Item kinds carried in tuser.
    typedef enum logic [1:0] {
        OP_PUSH  = 2'd0,
        OP_START = 2'd1,
        OP_FRAME = 2'd2,
        OP_NONE  = 2'd3
    } op_e;

    // Result status codes.
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_NEG  = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] REG_PRIO0    = 3'd0;
    localparam logic [2:0] REG_PRIO1    = 3'd1;
    localparam logic [2:0] REG_LEVEL0   = 3'd2;
    localparam logic [2:0] REG_LEVEL1   = 3'd3;
    localparam logic [2:0] REG_ATTACK0  = 3'd4;
    localparam logic [2:0] REG_ATTACK1  = 3'd5;
    localparam logic [2:0] REG_RELEASE0 = 3'd6;
    localparam logic [2:0] REG_RELEASE1 = 3'd7;

    // Datapath commands issued by the controller.
    typedef enum logic [4:0] {
        DP_IDLE,
        DP_LOAD,
        DP_PUSH,
        DP_START,
        DP_AUTO_JUMP,
        DP_AUTO_MUL,
        DP_AUTO_DIV,
        DP_AUTO_UPD,
        DP_DUCK_SET,
        DP_DUCK_DIV,
        DP_DUCK_UPD,
        DP_GAIN_MUL,
        DP_GAIN_TAKE,
        DP_MUL_L,
        DP_MUL_R,
        DP_ACC,
        DP_NEXT_SRC,
        DP_OUT
    } dp_cmd_e;

    typedef struct packed {
        dp_cmd_e op;
    } dp_cmd_t;

    typedef struct packed {
        op_e  item_op;
        logic src_active;
        logic src_last;
        logic queue_empty;
        logic len_zero;
        logic duck_direct;
        logic div_done;
    } dp_status_t;

endpackage
`default_nettype wire

FILE: rtl/core/dam_divider.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dam_divider
// Restoring divider, one quotient bit per cycle. The upper half of the
// dividend must be below the divisor, so the quotient fits in 32 bits.
// ----------------------------------------------------------------------------
module dam_divider (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [31:0] quotient
);

    logic [31:0] rem_reg;
    logic [31:0] low_reg;
    logic [31:0] div_reg;
    logic [31:0] quot_reg;
    logic [5:0]  count_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [32:0] trial;
    logic        fits;

    // Shift in the next dividend bit and try a subtraction.
    assign trial = {rem_reg, low_reg[31]};
    assign fits  = trial >= {1'b0, div_reg};

    // Iteration control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end else begin
            done_reg <= !start && busy_reg && (count_reg == 6'd1);
            if (start) begin
                busy_reg  <= 1'b1;
                count_reg <= 6'd32;
            end else if (busy_reg) begin
                count_reg <= count_reg - 6'd1;
                if (count_reg == 6'd1) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // Remainder and quotient registers.
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg  <= dividend[63:32];
            low_reg  <= dividend[31:0];
            div_reg  <= divisor;
            quot_reg <= '0;
        end else if (busy_reg) begin
            rem_reg  <= fits ? 32'(trial - {1'b0, div_reg}) : trial[31:0];
            low_reg  <= {low_reg[30:0], 1'b0};
            quot_reg <= {quot_reg[30:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule
`default_nettype wire

FILE: rtl/core/dam_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dam_datapath
// Configuration registers, per-source automation queues and gain state,
// the shared divider, the gain and sample multipliers and the mix sums.
// Each action is selected by a command from the controller.
// ----------------------------------------------------------------------------
module dam_datapath #(
    parameter int QUEUE_DEPTH = 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  dam_pkg::dp_cmd_t              cmd,
    output dam_pkg::dp_status_t           status,
    input  logic [dam_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic [dam_pkg::S_TUSER_W-1:0] s_tuser,
    input  logic                          cfg_we,
    input  logic [2:0]                    cfg_index,
    input  logic [31:0]                   cfg_data,
    output logic [dam_pkg::M_TDATA_W-1:0] m_tdata,
    output logic [dam_pkg::M_TUSER_W-1:0] m_tuser
);
    import dam_pkg::*;

    localparam int IW = $clog2(QUEUE_DEPTH);
    localparam int AW = $clog2(2 * QUEUE_DEPTH);
    localparam logic [IW-1:0] LAST_IDX = IW'(QUEUE_DEPTH - 1);
    localparam logic [AW-1:0] BANK1    = AW'(QUEUE_DEPTH);

    // Configuration registers.
    logic [7:0]  prio_reg    [SOURCES];
    logic [16:0] level_reg   [SOURCES];
    logic [31:0] attack_reg  [SOURCES];
    logic [31:0] release_reg [SOURCES];

    // Per-source state.
    logic [IW-1:0]      rd_reg     [SOURCES];
    logic [IW-1:0]      wr_reg     [SOURCES];
    logic [31:0]        pos_reg    [SOURCES];
    logic signed [31:0] auto_reg   [SOURCES];
    logic signed [31:0] duck_reg   [SOURCES];
    logic [16:0]        goal_reg   [SOURCES];
    logic [31:0]        span_reg   [SOURCES];
    logic               active_reg [SOURCES];
    logic               src_reg;

    // Latched item.
    op_e         op_reg;
    logic        isrc_reg;
    logic [31:0] seg_a_reg;
    logic [31:0] seg_b_reg;
    logic [31:0] seg_len_reg;
    logic [1:0]  mask_reg;
    logic [15:0] samp_reg [4];
    logic [1:0]  status_reg;

    // Segment memory: {length, end, start}.
    logic [95:0] seg_mem [2 * QUEUE_DEPTH];
    logic [95:0] seg_rd_reg;

    // Arithmetic registers.
    logic [63:0]        prod_reg;
    logic signed [31:0] g_reg;
    logic signed [48:0] lp_reg;
    logic signed [48:0] rp_reg;
    logic signed [31:0] suml_reg;
    logic signed [31:0] sumr_reg;
    logic [15:0]        outl_reg;
    logic [15:0]        outr_reg;
    logic [1:0]         outs_reg;

    function automatic logic [IW-1:0] idx_inc(input logic [IW-1:0] i);
        return (i == LAST_IDX) ? '0 : IW'(i + 1'b1);
    endfunction

    function automatic logic [AW-1:0] mem_addr(input logic s, input logic [IW-1:0] i);
        return s ? AW'(BANK1 + AW'(i)) : AW'(i);
    endfunction

    function automatic logic [15:0] clamp_out(input logic signed [31:0] v);
        logic [15:0] c;
        if (v > 32'sd32767)       c = 16'h7FFF;
        else if (v < -32'sd32768) c = 16'h8000;
        else                      c = v[15:0];
        return c ^ 16'h8000;
    endfunction

    // Push decode.
    logic [IW-1:0] push_wr;
    logic [IW-1:0] push_next;
    logic          push_neg;
    logic          push_full;
    assign push_wr   = wr_reg[isrc_reg];
    assign push_next = idx_inc(push_wr);
    assign push_neg  = seg_a_reg[31] | seg_b_reg[31];
    assign push_full = push_next == rd_reg[isrc_reg];

    // Segment fields of the current source.
    logic [31:0] seg_first;
    logic [31:0] seg_last;
    logic [31:0] seg_length;
    logic        seg_down;
    logic [31:0] seg_mag;
    logic [31:0] pos_inc;
    logic [31:0] auto_ramp;
    assign seg_first  = seg_rd_reg[31:0];
    assign seg_last   = seg_rd_reg[63:32];
    assign seg_length = seg_rd_reg[95:64];
    assign seg_down   = seg_last < seg_first;
    assign seg_mag    = seg_down ? seg_first - seg_last : seg_last - seg_first;
    assign pos_inc    = pos_reg[src_reg] + 32'd1;

    // Divider shared by the ramp interpolation and the duck step.
    logic        div_start;
    logic [63:0] div_dividend;
    logic [31:0] div_divisor;
    logic        div_done;
    logic [31:0] div_q;
    logic [31:0] duck_range;

    assign duck_range   = UNITY_WIDE - {15'd0, level_reg[src_reg]};
    assign div_start    = (cmd.op == DP_AUTO_DIV) || (cmd.op == DP_DUCK_DIV);
    assign div_dividend = (cmd.op == DP_AUTO_DIV) ? prod_reg : {32'd0, duck_range};
    assign div_divisor  = (cmd.op == DP_AUTO_DIV) ? seg_length : span_reg[src_reg];

    dam_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    assign auto_ramp = seg_first + (seg_down ? 32'(-div_q) : div_q);

    // Duck step toward the goal.
    logic signed [31:0] goal_wide;
    logic signed [31:0] gap;
    logic        [31:0] step0;
    logic signed [32:0] step;
    logic signed [32:0] gap_ext;
    logic               reach;
    logic signed [31:0] duck_new;

    assign goal_wide = $signed({15'd0, goal_reg[src_reg]});
    assign gap       = goal_wide - duck_reg[src_reg];
    assign gap_ext   = {gap[31], gap};
    assign step0     = (div_q == 32'd0) ? 32'd1 : div_q;
    assign step      = gap[31] ? -$signed({step0[31], step0}) : $signed({step0[31], step0});
    assign reach     = (!gap[31] && step >= gap_ext) || (gap[31] && step <= gap_ext);
    assign duck_new  = reach ? goal_wide : duck_reg[src_reg] + step[31:0];

    // Sample of the current source, moved to signed around the midpoint.
    logic signed [16:0] samp_l;
    logic signed [16:0] samp_r;
    assign samp_l = $signed({1'b0, samp_reg[{src_reg, 1'b0}]}) - $signed(MIDPOINT);
    assign samp_r = $signed({1'b0, samp_reg[{src_reg, 1'b1}]}) - $signed(MIDPOINT);

    // Block start: highest priority among the active sources.
    logic [7:0] top0;
    logic [7:0] top;
    assign top0 = mask_reg[0] ? prio_reg[0] : 8'd0;
    assign top  = (mask_reg[1] && prio_reg[1] > top0) ? prio_reg[1] : top0;

    // Control state: configuration, queues and gains.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 0; s < SOURCES; s++) begin
                prio_reg[s]    <= 8'(s);
                level_reg[s]   <= 17'd16384;
                attack_reg[s]  <= 32'd960;
                release_reg[s] <= 32'd12000;
                rd_reg[s]      <= '0;
                wr_reg[s]      <= '0;
                pos_reg[s]     <= '0;
                auto_reg[s]    <= $signed(UNITY_WIDE);
                duck_reg[s]    <= $signed(UNITY_WIDE);
                goal_reg[s]    <= UNITY_Q16;
                span_reg[s]    <= '0;
                active_reg[s]  <= 1'b0;
            end
            src_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    REG_PRIO0:    prio_reg[0]    <= cfg_data[7:0];
                    REG_PRIO1:    prio_reg[1]    <= cfg_data[7:0];
                    REG_LEVEL0:   level_reg[0]   <= cfg_data[16:0];
                    REG_LEVEL1:   level_reg[1]   <= cfg_data[16:0];
                    REG_ATTACK0:  attack_reg[0]  <= cfg_data;
                    REG_ATTACK1:  attack_reg[1]  <= cfg_data;
                    REG_RELEASE0: release_reg[0] <= cfg_data;
                    REG_RELEASE1: release_reg[1] <= cfg_data;
                    default: ;
                endcase
            end
            case (cmd.op)
                DP_LOAD: src_reg <= 1'b0;
                DP_PUSH: begin
                    if (!push_neg && !push_full) begin
                        wr_reg[isrc_reg] <= push_next;
                    end
                end
                DP_START: begin
                    for (int s = 0; s < SOURCES; s++) begin
                        logic [16:0] goal;
                        goal = (top > prio_reg[s]) ? level_reg[s] : UNITY_Q16;
                        goal_reg[s]   <= goal;
                        active_reg[s] <= mask_reg[s];
                        span_reg[s]   <= ($signed({15'd0, goal}) < duck_reg[s])
                                         ? attack_reg[s] : release_reg[s];
                    end
                end
                DP_AUTO_JUMP: begin
                    auto_reg[src_reg] <= $signed(seg_last);
                    rd_reg[src_reg]   <= idx_inc(rd_reg[src_reg]);
                    pos_reg[src_reg]  <= '0;
                end
                DP_AUTO_UPD: begin
                    if (pos_inc == seg_length) begin
                        auto_reg[src_reg] <= $signed(seg_last);
                        rd_reg[src_reg]   <= idx_inc(rd_reg[src_reg]);
                        pos_reg[src_reg]  <= '0;
                    end else begin
                        auto_reg[src_reg] <= $signed(auto_ramp);
                        pos_reg[src_reg]  <= pos_inc;
                    end
                end
                DP_DUCK_SET: duck_reg[src_reg] <= goal_wide;
                DP_DUCK_UPD: duck_reg[src_reg] <= duck_new;
                DP_NEXT_SRC: src_reg <= 1'b1;
                default: ;
            endcase
        end
    end

    // Segment memory write and registered read.
    always_ff @(posedge aclk) begin
        if (cmd.op == DP_PUSH && !push_neg && !push_full) begin
            seg_mem[mem_addr(isrc_reg, push_wr)] <= {seg_len_reg, seg_b_reg, seg_a_reg};
        end
        seg_rd_reg <= seg_mem[mem_addr(src_reg, rd_reg[src_reg])];
    end

    // Item latch, arithmetic and output registers.
    always_ff @(posedge aclk) begin
        case (cmd.op)
            DP_LOAD: begin
                op_reg      <= op_e'(s_tuser[1:0]);
                isrc_reg    <= s_tuser[2];
                seg_a_reg   <= s_tdata[31:0];
                seg_b_reg   <= s_tdata[63:32];
                seg_len_reg <= s_tdata[95:64];
                mask_reg    <= s_tdata[97:96];
                samp_reg[0] <= s_tdata[113:98];
                samp_reg[1] <= s_tdata[129:114];
                samp_reg[2] <= s_tdata[145:130];
                samp_reg[3] <= s_tdata[161:146];
                status_reg  <= ST_OK;
                suml_reg    <= '0;
                sumr_reg    <= '0;
            end
            DP_PUSH: begin
                if (push_neg)       status_reg <= ST_NEG;
                else if (push_full) status_reg <= ST_FULL;
            end
            DP_AUTO_MUL:  prod_reg <= seg_mag * pos_reg[src_reg];
            DP_GAIN_MUL:  prod_reg <= 64'(auto_reg[src_reg] * duck_reg[src_reg]);
            DP_GAIN_TAKE: g_reg    <= $signed(prod_reg[FRAC_BITS +: 32]);
            DP_MUL_L:     lp_reg   <= samp_l * g_reg;
            DP_MUL_R: begin
                rp_reg   <= samp_r * g_reg;
                suml_reg <= suml_reg + $signed(lp_reg[FRAC_BITS +: 32]);
            end
            DP_ACC: sumr_reg <= sumr_reg + $signed(rp_reg[FRAC_BITS +: 32]);
            DP_OUT: begin
                outs_reg <= status_reg;
                outl_reg <= (op_reg == OP_FRAME) ? clamp_out(suml_reg) : 16'd0;
                outr_reg <= (op_reg == OP_FRAME) ? clamp_out(sumr_reg) : 16'd0;
            end
            default: ;
        endcase
    end

    // Status towards the controller.
    assign status.item_op     = op_reg;
    assign status.src_active  = active_reg[src_reg];
    assign status.src_last    = src_reg;
    assign status.queue_empty = rd_reg[src_reg] == wr_reg[src_reg];
    assign status.len_zero    = seg_length == 32'd0;
    assign status.duck_direct = (span_reg[src_reg] == 32'd0) || (gap == 32'sd0);
    assign status.div_done    = div_done;

    assign m_tdata = {outr_reg, outl_reg};
    assign m_tuser = outs_reg;

endmodule
`default_nettype wire

FILE: rtl/core/dam_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dam_ctrl
// Sequencer of the mixer: takes one item, walks the datapath through the
// push, block start or per-source frame steps, and holds the result valid.
// ----------------------------------------------------------------------------
module dam_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    output dam_pkg::dp_cmd_t    cmd,
    input  dam_pkg::dp_status_t status
);
    import dam_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_CHECK,
        S_AUTO,
        S_ADIV_GO,
        S_ADIV_WAIT,
        S_DUCK,
        S_DDIV_WAIT,
        S_GAIN,
        S_GTAKE,
        S_MULL,
        S_MULR,
        S_ACC,
        S_NEXT,
        S_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_tvalid_reg;
    logic   out_free;

    assign s_tready = state_reg == S_IDLE;
    assign out_free = !m_tvalid_reg || m_tready;

    // Next state and datapath command.
    always_comb begin
        state_next = state_reg;
        cmd.op     = DP_IDLE;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.op     = DP_LOAD;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (status.item_op)
                    OP_PUSH: begin
                        cmd.op     = DP_PUSH;
                        state_next = S_FINISH;
                    end
                    OP_START: begin
                        cmd.op     = DP_START;
                        state_next = S_FINISH;
                    end
                    OP_FRAME: state_next = S_CHECK;
                    default:  state_next = S_FINISH;
                endcase
            end
            S_CHECK: state_next = status.src_active ? S_AUTO : S_NEXT;
            S_AUTO: begin
                if (status.queue_empty) begin
                    state_next = S_DUCK;
                end else if (status.len_zero) begin
                    cmd.op     = DP_AUTO_JUMP;
                    state_next = S_DUCK;
                end else begin
                    cmd.op     = DP_AUTO_MUL;
                    state_next = S_ADIV_GO;
                end
            end
            S_ADIV_GO: begin
                cmd.op     = DP_AUTO_DIV;
                state_next = S_ADIV_WAIT;
            end
            S_ADIV_WAIT: begin
                if (status.div_done) begin
                    cmd.op     = DP_AUTO_UPD;
                    state_next = S_DUCK;
                end
            end
            S_DUCK: begin
                if (status.duck_direct) begin
                    cmd.op     = DP_DUCK_SET;
                    state_next = S_GAIN;
                end else begin
                    cmd.op     = DP_DUCK_DIV;
                    state_next = S_DDIV_WAIT;
                end
            end
            S_DDIV_WAIT: begin
                if (status.div_done) begin
                    cmd.op     = DP_DUCK_UPD;
                    state_next = S_GAIN;
                end
            end
            S_GAIN: begin
                cmd.op     = DP_GAIN_MUL;
                state_next = S_GTAKE;
            end
            S_GTAKE: begin
                cmd.op     = DP_GAIN_TAKE;
                state_next = S_MULL;
            end
            S_MULL: begin
                cmd.op     = DP_MUL_L;
                state_next = S_MULR;
            end
            S_MULR: begin
                cmd.op     = DP_MUL_R;
                state_next = S_ACC;
            end
            S_ACC: begin
                cmd.op     = DP_ACC;
                state_next = S_NEXT;
            end
            S_NEXT: begin
                if (status.src_last) begin
                    state_next = S_FINISH;
                end else begin
                    cmd.op     = DP_NEXT_SRC;
                    state_next = S_CHECK;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    cmd.op     = DP_OUT;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // State and result valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_FINISH && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;

`ifndef NO_ASSERTIONS
    // The divider only completes while the sequencer waits for it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        status.div_done |-> (state_reg == S_ADIV_WAIT || state_reg == S_DDIV_WAIT))
        else $error("divider finished outside a wait state");

    // A new result appears only out of the finishing step.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg) == S_FINISH)
        else $error("result raised without finishing an item");

    // Per-source frame steps run only for frame items.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CHECK) |-> (status.item_op == OP_FRAME))
        else $error("frame sequence entered for a non-frame item");
`endif

endmodule
`default_nettype wire

FILE: rtl/core/ducking_automation_mixer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ducking_automation_mixer
// Two-source stereo mixer with queued Q16 gain automation and priority
// ducking.
//
// Input stream: s_tuser carries the item kind (push segment, block start,
// mix frame) and the target source; s_tdata carries the segment, the active
// mask and the four offset-binary samples. Each item gives one result on the
// m_ stream: mixed left and right samples in m_tdata and a status in m_tuser.
// Configuration registers are written over cfg_valid/cfg_index/cfg_data,
// which is always ready; the user must write them only while the mixer is
// idle, as the mixer itself does not enforce this. Items are handled one
// at a time. A push, block start or unused item passes through the decode
// and finishing steps; a frame takes longest when both sources are active
// with a ramp and a duck step each (two passes through the shared divider
// per source). s_tready returns in the same cycle as the result is presented.
// Reset (aresetn, synchronous) restores the register defaults, empties the
// automation queues and sets both gains to unity with no source active.
// A stalled result is held in the output register; the next item is taken
// meanwhile, and its result waits until the held one is transferred.
// ----------------------------------------------------------------------------
module ducking_automation_mixer #(
    parameter int QUEUE_DEPTH = 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [31:0] seg_start_gain, [63:32] seg_end_gain, [95:64] seg_frames,
    // [97:96] active_mask, [113:98] left_src0, [129:114] right_src0,
    // [145:130] left_src1, [161:146] right_src1, [167:162] zero
    input  logic [dam_pkg::S_TDATA_W-1:0] s_tdata,
    // [1:0] operation, [2] source
    input  logic [dam_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [15:0] mix_left, [31:16] mix_right
    output logic [dam_pkg::M_TDATA_W-1:0] m_tdata,
    // [1:0] status
    output logic [dam_pkg::M_TUSER_W-1:0] m_tuser,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [2:0]                    cfg_index,
    input  logic [31:0]                   cfg_data
);
    import dam_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    // Sequencer.
    dam_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .status   (status)
    );

    // Arithmetic, state and storage.
    dam_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule
`default_nettype wire

FILE: tb/ducking_automation_mixer_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ducking_automation_mixer_tb
// Self-checking bench for the two-source ducking automation mixer. A directed
// table of items runs first, then several phases of random pushes, block
// starts and frames under different register settings. Every result transfer
// is compared with a value from the directed table or with a behavioural model.
// ----------------------------------------------------------------------------
module ducking_automation_mixer_tb;
    import dam_pkg::*;

    localparam int DEPTH      = 8;
    localparam int STALL_MAX  = 20000;
    localparam int RANDOM_PER = 150;

    typedef struct {
        op_e         op;
        bit          src;
        logic [31:0] g_start;
        logic [31:0] g_end;
        logic [31:0] frames;
        logic [1:0]  mask;
        logic [15:0] l0, r0, l1, r1;
    } mix_item_t;

    typedef struct {
        logic [15:0] left;
        logic [15:0] right;
        logic [1:0]  status;
    } mix_result_t;

    typedef struct {
        mix_item_t   item;
        bit          typed;
        mix_result_t res;
    } table_row_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [S_TUSER_W-1:0] s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [2:0]           cfg_index = '0;
    logic [31:0]          cfg_data = '0;

    ducking_automation_mixer dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #10 aclk = ~aclk;

    // Register copies held by the mixer model.
    logic [7:0]  prio [2];
    logic [16:0] level [2];
    logic [31:0] attack [2];
    logic [31:0] rel [2];

    // Mixer model state.
    logic [31:0] seg_start [2][DEPTH];
    logic [31:0] seg_end [2][DEPTH];
    logic [31:0] seg_len [2][DEPTH];
    int          rd_idx [2];
    int          wr_idx [2];
    logic [31:0] ramp_pos [2];
    longint      auto_g [2];
    longint      duck_g [2];
    longint      duck_target [2];
    logic [31:0] duck_frames [2];
    bit          active [2];

    mix_result_t expected_mix [$];
    int          mismatches = 0;
    int          idle_cycles = 0;
    bit          steady = 1'b0;
    table_row_t  directed [$];

    function automatic longint wrap32(longint x);
        logic [31:0] v;
        v = x[31:0];
        return longint'($signed(v));
    endfunction

    // Next automation gain of one source; consumes one frame of its ramp.
    function automatic longint ramp_gain_next(int s);
        int          r;
        longint      first, last, delta, quot;
        logic [31:0] len;
        logic [63:0] mag, q;
        r = rd_idx[s];
        if (r == wr_idx[s])
            return auto_g[s];
        first = wrap32(longint'(seg_start[s][r]));
        last  = wrap32(longint'(seg_end[s][r]));
        len   = seg_len[s][r];
        if (len == 0) begin
            auto_g[s] = last;
            rd_idx[s] = (r + 1) % DEPTH;
            ramp_pos[s] = 0;
            return last;
        end
        delta = last - first;
        mag = (delta < 0) ? -delta : delta;
        q = mag * {32'b0, ramp_pos[s]} / {32'b0, len};
        quot = (delta < 0) ? -longint'(q) : longint'(q);
        auto_g[s] = wrap32(first + wrap32(quot));
        ramp_pos[s] = ramp_pos[s] + 1;
        if (ramp_pos[s] >= len) begin
            auto_g[s] = last;
            rd_idx[s] = (r + 1) % DEPTH;
            ramp_pos[s] = 0;
        end
        return auto_g[s];
    endfunction

    // One linear step of the duck gain toward its target, at least 1 per frame.
    function automatic longint duck_step(longint cur, longint target, longint range,
                                         logic [31:0] span);
        longint      gap, stp;
        logic [31:0] rr;
        gap = wrap32(target - cur);
        if (span == 0 || gap == 0)
            return target;
        rr = range[31:0];
        stp = wrap32(longint'(rr / span));
        if (stp == 0)
            stp = 1;
        if (gap < 0)
            stp = -stp;
        if ((gap > 0 && stp >= gap) || (gap < 0 && stp <= gap))
            return target;
        return wrap32(cur + stp);
    endfunction

    function automatic mix_result_t mix_predict(mix_item_t it);
        mix_result_t res;
        int          s, nxt;
        logic [7:0]  top;
        longint      g, target, sl, sr, l, r;
        logic [15:0] smp_l [2];
        logic [15:0] smp_r [2];
        res = '{16'd0, 16'd0, ST_OK};
        smp_l = '{it.l0, it.l1};
        smp_r = '{it.r0, it.r1};
        case (it.op)
            OP_PUSH: begin
                s = it.src;
                if (it.g_start[31] || it.g_end[31]) begin
                    res.status = ST_NEG;
                end else begin
                    nxt = (wr_idx[s] + 1) % DEPTH;
                    if (nxt == rd_idx[s]) begin
                        res.status = ST_FULL;
                    end else begin
                        seg_start[s][wr_idx[s]] = it.g_start;
                        seg_end[s][wr_idx[s]]   = it.g_end;
                        seg_len[s][wr_idx[s]]   = it.frames;
                        wr_idx[s] = nxt;
                    end
                end
            end
            OP_START: begin
                top = 0;
                for (s = 0; s < 2; s++) begin
                    active[s] = it.mask[s];
                    if (active[s] && prio[s] > top)
                        top = prio[s];
                end
                for (s = 0; s < 2; s++) begin
                    target = (top > prio[s]) ? longint'(level[s]) : 65536;
                    duck_target[s] = target;
                    duck_frames[s] = (target < duck_g[s]) ? attack[s] : rel[s];
                end
            end
            OP_FRAME: begin
                sl = 0;
                sr = 0;
                for (s = 0; s < 2; s++) begin
                    if (active[s]) begin
                        g = ramp_gain_next(s);
                        duck_g[s] = duck_step(duck_g[s], duck_target[s],
                                              65536 - longint'(level[s]), duck_frames[s]);
                        g = wrap32((g * duck_g[s]) >>> 16);
                        l = longint'(smp_l[s]) - 32768;
                        r = longint'(smp_r[s]) - 32768;
                        sl = wrap32(sl + wrap32((l * g) >>> 16));
                        sr = wrap32(sr + wrap32((r * g) >>> 16));
                    end
                end
                if (sl > 32767) sl = 32767;
                if (sl < -32768) sl = -32768;
                if (sr > 32767) sr = 32767;
                if (sr < -32768) sr = -32768;
                res.left  = 16'(sl + 32768);
                res.right = 16'(sr + 32768);
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic mix_item_t make_item(op_e op, bit src, logic [31:0] ga,
                                            logic [31:0] gb, logic [31:0] n,
                                            logic [1:0] mask, logic [15:0] smp);
        mix_item_t it;
        it = '{op, src, ga, gb, n, mask, smp, smp, ~smp, ~smp};
        return it;
    endfunction

    function automatic mix_item_t random_item();
        mix_item_t it;
        int        pick;
        pick = $urandom_range(0, 99);
        it = make_item(OP_FRAME, $urandom_range(0, 1), 0, 0, 0, $urandom_range(0, 3), 0);
        it.l0 = $urandom; it.r0 = $urandom; it.l1 = $urandom; it.r1 = $urandom;
        if (pick < 3) begin
            it.op = OP_NONE;
            it.g_start = $urandom; it.g_end = $urandom; it.frames = $urandom;
        end else if (pick < 12) begin
            it.op = OP_START;
        end else if (pick < 50) begin
            it.op = OP_PUSH;
            for (int k = 0; k < 2; k++) begin
                pick = $urandom_range(0, 99);
                if (pick < 85)
                    it.g_end = $urandom_range(0, 131072);
                else if (pick < 95)
                    it.g_end = $urandom & 32'h7FFF_FFFF;
                else
                    it.g_end = $urandom;
                if (k == 0)
                    it.g_start = it.g_end;
            end
            pick = $urandom_range(0, 99);
            it.frames = (pick < 70) ? $urandom_range(0, 12) :
                        (pick < 90) ? $urandom_range(0, 200) : $urandom;
        end
        return it;
    endfunction

    // Sends one item over the input stream and records its expected result.
    task automatic send_item(mix_item_t it, bit typed, mix_result_t typed_res);
        mix_result_t pred;
        forever begin
            @(negedge aclk);
            if (!steady && $urandom_range(0, 99) < 37)
                s_tvalid <= 1'b0;
            else
                break;
        end
        s_tvalid <= 1'b1;
        s_tuser  <= {it.src, it.op};
        s_tdata  <= {6'b0, it.r1, it.l1, it.r0, it.l0, it.mask, it.frames,
                     it.g_end, it.g_start};
        do @(posedge aclk); while (!s_tready);
        pred = mix_predict(it);
        expected_mix.push_back(typed ? typed_res : pred);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_PRIO0:    prio[0]   = val[7:0];
            REG_PRIO1:    prio[1]   = val[7:0];
            REG_LEVEL0:   level[0]  = val[16:0];
            REG_LEVEL1:   level[1]  = val[16:0];
            REG_ATTACK0:  attack[0] = val;
            REG_ATTACK1:  attack[1] = val;
            REG_RELEASE0: rel[0]    = val;
            default:      rel[1]    = val;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_mix.size() != 0)
            @(posedge aclk);
    endtask

    task automatic add_row(mix_item_t it, bit typed, logic [15:0] l, logic [15:0] r,
                           logic [1:0] st);
        table_row_t row;
        row.item = it;
        row.typed = typed;
        row.res = '{l, r, st};
        directed.push_back(row);
    endtask

    // The sink side stalls at random apart from the steady stretch.
    always @(negedge aclk)
        if (aresetn)
            m_tready <= steady || ($urandom_range(0, 99) >= 37);

    // Result checking against the oldest expectation.
    always @(posedge aclk) begin
        mix_result_t want;
        if (m_tvalid && m_tready) begin
            if (expected_mix.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result transfer: data %h status %0d",
                             m_tdata, m_tuser);
            end else begin
                want = expected_mix.pop_front();
                if (m_tdata[15:0] !== want.left || m_tdata[31:16] !== want.right ||
                    m_tuser !== want.status) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: expected L %h R %h st %0d, got L %h R %h st %0d",
                                 want.left, want.right, want.status,
                                 m_tdata[15:0], m_tdata[31:16], m_tuser);
                end
            end
        end
    end

    // Cycles with no transfer on any channel.
    always @(posedge aclk)
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;

    initial begin
        while (idle_cycles < STALL_MAX)
            @(posedge aclk);
        $display("ducking_automation_mixer test failed");
        $finish;
    end

    initial begin
        mix_item_t it;
        for (int s = 0; s < 2; s++) begin
            prio[s] = s; level[s] = 17'd16384; attack[s] = 960; rel[s] = 12000;
            rd_idx[s] = 0; wr_idx[s] = 0; ramp_pos[s] = 0;
            auto_g[s] = 65536; duck_g[s] = 65536; duck_target[s] = 65536;
            duck_frames[s] = 0; active[s] = 0;
        end

        // Directed items: silence before any block start, the unused code,
        // rejected gains, a full queue, jumps, extremes and each active mask.
        add_row(make_item(OP_FRAME, 0, 0, 0, 0, 0, 16'hFFFF), 1, 16'h8000, 16'h8000, ST_OK);
        add_row(make_item(OP_NONE, 1, '1, '1, '1, 3, 16'hFFFF), 1, 0, 0, ST_OK);
        add_row(make_item(OP_PUSH, 0, 32'hFFFF_FFFF, 0, 4, 0, 0), 1, 0, 0, ST_NEG);
        add_row(make_item(OP_PUSH, 1, 0, 32'h8000_0000, 4, 0, 0), 1, 0, 0, ST_NEG);
        for (int k = 0; k < 7; k++)
            add_row(make_item(OP_PUSH, 0, 32'(k * 16384), 32'(65536 - k * 8192), k % 3, 0, 0),
                    1, 0, 0, ST_OK);
        add_row(make_item(OP_PUSH, 0, 0, 0, 0, 0, 0), 1, 0, 0, ST_FULL);
        add_row(make_item(OP_PUSH, 1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, '1, 0, 0), 1, 0, 0, ST_OK);
        add_row(make_item(OP_START, 0, 0, 0, 0, 3, 0), 1, 0, 0, ST_OK);
        add_row(make_item(OP_FRAME, 0, 0, 0, 0, 0, 16'h0000), 0, 0, 0, ST_OK);
        add_row(make_item(OP_FRAME, 0, 0, 0, 0, 0, 16'hFFFF), 0, 0, 0, ST_OK);
        add_row(make_item(OP_FRAME, 0, 0, 0, 0, 0, 16'h1234), 0, 0, 0, ST_OK);
        add_row(make_item(OP_START, 0, 0, 0, 0, 1, 0), 1, 0, 0, ST_OK);
        add_row(make_item(OP_FRAME, 0, 0, 0, 0, 0, 16'hC000), 0, 0, 0, ST_OK);
        add_row(make_item(OP_START, 0, 0, 0, 0, 2, 0), 1, 0, 0, ST_OK);
        add_row(make_item(OP_FRAME, 0, 0, 0, 0, 0, 16'h4000), 0, 0, 0, ST_OK);
        add_row(make_item(OP_START, 0, 0, 0, 0, 0, 0), 1, 0, 0, ST_OK);
        add_row(make_item(OP_FRAME, 0, 0, 0, 0, 0, 16'h0000), 1, 16'h8000, 16'h8000, ST_OK);

        // Reset is held first, then released on a falling edge.
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed[i])
            send_item(directed[i].item, directed[i].typed, directed[i].res);
        drain();

        // Random phases, each under a fresh register setting written while idle.
        for (int ph = 0; ph < 4; ph++) begin
            for (int idx = 0; idx < 8; idx++) begin
                logic [31:0] val;
                case (ph)
                    0: val = 0;
                    1: val = (idx < 2) ? 32'd255 : (idx < 4) ? 32'd65536 : 32'hFFFF_FFFF;
                    default: val = (idx < 2) ? $urandom_range(0, 255) :
                                   (idx < 4) ? $urandom_range(0, 65536) :
                                   ($urandom_range(0, 3) == 0) ? $urandom :
                                   $urandom_range(0, 40);
                endcase
                write_reg(3'(idx), val);
            end
            for (int n = 0; n < RANDOM_PER; n++) begin
                steady = (ph == 2 && n >= 30 && n < 100);
                it = random_item();
                send_item(it, 0, '{16'd0, 16'd0, ST_OK});
            end
            steady = 1'b0;
            drain();
        end

        repeat (200) @(posedge aclk);
        if (mismatches == 0)
            $display("ducking_automation_mixer test passed");
        else
            $display("ducking_automation_mixer test failed");
        $finish;
    end

endmodule
